// ===== src/strided_interval_intersect_merge_core_macros.svh =====
// Assertion macros used by the RTL of the strided interval core.
`ifndef STRIDED_INTERVAL_INTERSECT_MERGE_CORE_MACROS_SVH
`define STRIDED_INTERVAL_INTERSECT_MERGE_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SIIM_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SIIM_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/siim_pkg.sv =====
`default_nettype none
package siim_pkg;

    localparam int VW    = 32;
    localparam int SW    = 16;
    localparam int LW    = 2 * SW;
    localparam int DIV_W = (VW > LW) ? VW : LW;
    localparam int CNT_W = $clog2(DIV_W + 1);
    localparam int RES_W = 32;

    // Operation selector codes.
    localparam logic FUNC_ISECT   = 1'b0;
    localparam logic FUNC_COMPACT = 1'b1;

    typedef struct packed {
        logic                 func;
        logic signed [VW-1:0] a_begin;
        logic [SW-1:0]        a_step;
        logic signed [VW-1:0] a_end;
        logic signed [VW-1:0] b_begin;
        logic [SW-1:0]        b_step;
        logic signed [VW-1:0] b_end;
    } t_in;

    typedef struct packed {
        logic signed [RES_W-1:0] res_begin;
        logic [RES_W-1:0]        res_step;
        logic signed [RES_W-1:0] res_end;
        logic                    res_empty;
        logic                    res_valid;
    } t_out;

    // Control of the shared divider: start pulse and operand width select.
    typedef struct packed {
        logic start;
        logic long_mode;
    } t_div_ctl;

    typedef enum logic [4:0] {
        S_IDLE, S_NA, S_NA2, S_NB, S_NB2, S_DISP, S_ICHK,
        S_EDIV, S_EMUL, S_EUPD, S_XG, S_MG, S_LCM, S_INV,
        S_R1, S_R2, S_R1Y, S_DG, S_QI, S_K, S_T, S_TCHK,
        S_FN, S_FN2, S_DIVW, S_OUT
    } t_state;

endpackage
`default_nettype wire

// ===== src/siim_div.sv =====
`default_nettype none
// Restoring divider, one quotient bit per cycle.
module siim_div import siim_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_div_ctl         i_ctl,
    input  wire logic [DIV_W-1:0] i_dividend,
    input  wire logic [LW-1:0]    i_divisor,
    output logic                  o_done,
    output logic [DIV_W-1:0]      o_quo,
    output logic [LW-1:0]         o_rem
);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DIV_W-1:0] r_quo;
    logic [LW-1:0]    r_rem;
    logic [LW-1:0]    r_dvs;

    logic [LW:0]   w_trial;
    logic [LW:0]   w_diff;
    logic          w_fits;
    logic [LW-1:0] n_rem;

    always_comb begin
        w_trial = {r_rem, r_quo[DIV_W-1]};
        w_diff  = w_trial - {1'b0, r_dvs};
        w_fits  = w_trial >= {1'b0, r_dvs};
        n_rem   = w_fits ? w_diff[LW-1:0] : w_trial[LW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_ctl.long_mode ? CNT_W'(DIV_W) : CNT_W'(SW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_quo <= i_ctl.long_mode ? i_dividend : (i_dividend << (DIV_W - SW));
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DIV_W-2:0], w_fits};
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;

endmodule
`default_nettype wire

// ===== src/strided_interval_intersect_merge_core.sv =====
`default_nettype none
// Strided interval intersect and merge core.
// The input channel (i_valid, i_in, o_stall) carries one transaction with two strided
// intervals and a selector: intersection or compact (merge of equal-step intervals).
// The output channel (o_valid, o_out, i_stall) returns exactly one result transaction
// for each input transaction, normalized, with the empty code begin 1, step 1, end 0.
// One item is worked at a time: o_stall is high from acceptance until the result has
// been moved into the output register. Every remainder, quotient and gcd step runs
// through one shared restoring divider that retires one bit per cycle, plus one
// registered 16x16 multiplier.
// Unequal compact steps, empty operands and disjoint ranges finish soonest, and a
// compact merge of adjacent intervals next. A nonempty intersection, and a merge of
// overlapping intervals, takes longest, set by the number of Euclid steps and by the
// seven value-wide divisions. The next item can be accepted in the cycle after the
// result moves out.
// The output register lets the next item be accepted while a result still waits;
// when the receiver stalls, the result holds and the next finished result waits in
// the sequencer until the register frees up.
// Reset is synchronous and active low; it returns the sequencer to idle and drops
// o_valid. A result in flight or waiting in the output register is lost at reset.
`include "strided_interval_intersect_merge_core_macros.svh"
module strided_interval_intersect_merge_core import siim_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    input  wire t_in  i_in,
    output logic      o_stall,
    output logic      o_valid,
    output t_out      o_out,
    input  wire logic i_stall
);

    // Sequencer state and the state to resume once the divider finishes.
    t_state r_state, n_state;
    t_state r_ret, w_ret;

    // Normalized operands.
    logic                 r_func;
    logic signed [VW-1:0] r_ab, r_ae, r_bb, r_be;
    logic [SW-1:0]        r_as, r_bs;

    // Intersection working registers.
    logic signed [VW-1:0] r_maxb, r_mine;
    logic [SW-1:0]        r_eor, r_er;
    logic signed [LW:0]   r_eos, r_es;
    logic [SW-1:0]        r_xp, r_m2, r_inv, r_r1, r_r2;
    logic [LW-1:0]        r_lcm;
    logic [LW-1:0]        r_prod;

    // Operands of the final normalization.
    logic signed [VW-1:0] r_fb, r_fe;
    logic [LW-1:0]        r_fs;

    // Result waiting for the output register.
    logic signed [VW-1:0] r_rb, r_re;
    logic [LW-1:0]        r_rs;
    logic                 r_rempty, r_rvalid;

    logic r_ovalid;
    t_out r_out;

    // Shared divider and multiplier connections.
    t_div_ctl         w_ctl;
    logic [DIV_W-1:0] w_dividend;
    logic [LW-1:0]    w_divisor;
    logic             w_done;
    logic [DIV_W-1:0] w_quo;
    logic [LW-1:0]    w_rem;
    logic [SW-1:0]    w_ma, w_mb;

    siim_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_ctl),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_done     (w_done),
        .o_quo      (w_quo),
        .o_rem      (w_rem)
    );

    // Helper values derived from the working registers.
    logic                 w_accept;
    logic [VW-1:0]        w_span_a, w_span_b, w_span_f, w_span_i;
    logic [VW-1:0]        w_off_a, w_off_b;
    logic signed [VW-1:0] w_ae_rnd, w_be_rnd, w_fe_rnd;
    logic                 w_eq_step, w_c1, w_c2, w_iempty;
    logic [LW:0]          w_es_mag, w_eos_mag, w_enew;
    logic [SW:0]          w_dsum;
    logic [SW-1:0]        w_d;
    logic [LW:0]          w_t;
    logic                 w_t_over;
    logic                 w_out_load;

    // Terms watched by the assertions.
    logic w_empty_out, w_code_ok, w_reject_out;

    always_comb begin
        w_accept  = i_valid && !o_stall;
        w_span_a  = r_ae - r_ab;
        w_span_b  = r_be - r_bb;
        w_span_f  = r_fe - r_fb;
        w_span_i  = r_mine - r_maxb;
        w_off_a   = r_maxb - r_ab;
        w_off_b   = r_maxb - r_bb;
        w_ae_rnd  = r_ae - VW'(w_rem);
        w_be_rnd  = r_be - VW'(w_rem);
        w_fe_rnd  = r_fe - VW'(w_rem);
        w_eq_step = r_as == r_bs;
        w_c1      = w_eq_step && (r_bb > r_ae) && (VW'(r_bb - r_ae) == VW'(r_as));
        w_c2      = w_eq_step && (r_ab > r_be) && (VW'(r_ab - r_be) == VW'(r_as));
        w_iempty  = (r_ae < r_ab) || (r_be < r_bb) || (r_ae < r_bb) || (r_be < r_ab);
        w_es_mag  = r_es[LW] ? -r_es : r_es;
        w_eos_mag = r_eos[LW] ? -r_eos : r_eos;
        // Extended Euclid coefficient update: s_new = s_old - q * s.
        w_enew    = r_es[LW] ? (r_eos + {1'b0, r_prod}) : (r_eos - {1'b0, r_prod});
        // Difference of the two residues modulo the second stride.
        w_dsum    = {1'b0, r_r2} + {1'b0, r_bs} - {1'b0, w_rem[SW-1:0]};
        w_d       = (w_dsum >= {1'b0, r_bs}) ? SW'(w_dsum - {1'b0, r_bs}) : w_dsum[SW-1:0];
        w_t       = {1'b0, r_prod} + (LW+1)'(r_r1);
        w_t_over  = (DIV_W+1)'(w_t) > (DIV_W+1)'(w_span_i);
        w_out_load = (r_state == S_OUT) && (!r_ovalid || !i_stall);
    end

    // Divider and multiplier operand selection.
    always_comb begin
        w_ctl      = '0;
        w_dividend = '0;
        w_divisor  = '0;
        w_ret      = S_IDLE;
        w_ma       = '0;
        w_mb       = '0;
        unique case (r_state)
            S_NA: begin
                w_ctl      = '{start: !(r_ae < r_ab), long_mode: 1'b1};
                w_dividend = DIV_W'(w_span_a);
                w_divisor  = LW'(r_as);
                w_ret      = S_NA2;
            end
            S_NB: begin
                w_ctl      = '{start: !(r_be < r_bb), long_mode: 1'b1};
                w_dividend = DIV_W'(w_span_b);
                w_divisor  = LW'(r_bs);
                w_ret      = S_NB2;
            end
            S_EDIV: begin
                w_ctl      = '{start: 1'b1, long_mode: 1'b0};
                w_dividend = DIV_W'(r_eor);
                w_divisor  = LW'(r_er);
                w_ret      = S_EMUL;
            end
            S_EMUL: begin
                w_ma = w_quo[SW-1:0];
                w_mb = w_es_mag[SW-1:0];
            end
            S_XG: begin
                w_ctl      = '{start: 1'b1, long_mode: 1'b0};
                w_dividend = DIV_W'(r_as);
                w_divisor  = LW'(r_eor);
                w_ret      = S_MG;
            end
            S_MG: begin
                w_ctl      = '{start: 1'b1, long_mode: 1'b0};
                w_dividend = DIV_W'(r_bs);
                w_divisor  = LW'(r_eor);
                w_ret      = S_LCM;
            end
            S_LCM: begin
                w_ma = r_xp;
                w_mb = r_bs;
            end
            S_INV: begin
                w_ctl      = '{start: 1'b1, long_mode: 1'b1};
                w_dividend = DIV_W'(w_eos_mag[LW-1:0]);
                w_divisor  = LW'(r_m2);
                w_ret      = S_R1;
            end
            S_R1: begin
                w_ctl      = '{start: 1'b1, long_mode: 1'b1};
                w_dividend = DIV_W'(w_off_a);
                w_divisor  = LW'(r_as);
                w_ret      = S_R2;
            end
            S_R2: begin
                w_ctl      = '{start: 1'b1, long_mode: 1'b1};
                w_dividend = DIV_W'(w_off_b);
                w_divisor  = LW'(r_bs);
                w_ret      = S_R1Y;
            end
            S_R1Y: begin
                w_ctl      = '{start: 1'b1, long_mode: 1'b0};
                w_dividend = DIV_W'(r_r1);
                w_divisor  = LW'(r_bs);
                w_ret      = S_DG;
            end
            S_DG: begin
                w_ctl      = '{start: 1'b1, long_mode: 1'b0};
                w_dividend = DIV_W'(w_d);
                w_divisor  = LW'(r_eor);
                w_ret      = S_QI;
            end
            S_QI: begin
                w_ma = w_quo[SW-1:0];
                w_mb = r_inv;
            end
            S_K: begin
                w_ctl      = '{start: 1'b1, long_mode: 1'b1};
                w_dividend = DIV_W'(r_prod);
                w_divisor  = LW'(r_m2);
                w_ret      = S_T;
            end
            S_T: begin
                w_ma = r_as;
                w_mb = w_rem[SW-1:0];
            end
            S_FN: begin
                w_ctl      = '{start: !(r_fe < r_fb), long_mode: 1'b1};
                w_dividend = DIV_W'(w_span_f);
                w_divisor  = r_fs;
                w_ret      = S_FN2;
            end
            default: begin
                w_ctl = '0;
            end
        endcase
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state) inside
            S_IDLE:  n_state = w_accept ? S_NA : S_IDLE;
            S_NA:    n_state = w_ctl.start ? S_DIVW : S_NB;
            S_NA2:   n_state = S_NB;
            S_NB:    n_state = w_ctl.start ? S_DIVW : S_DISP;
            S_NB2:   n_state = S_DISP;
            S_DISP: begin
                if (r_func == FUNC_ISECT) begin
                    n_state = S_ICHK;
                end else if (w_c1 || w_c2) begin
                    n_state = S_FN;
                end else if (w_eq_step) begin
                    n_state = S_ICHK;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_ICHK:  n_state = w_iempty ? S_OUT : S_EDIV;
            S_EMUL:  n_state = S_EUPD;
            S_EUPD:  n_state = (w_rem[SW-1:0] == '0) ? S_XG : S_EDIV;
            S_LCM:   n_state = S_INV;
            S_QI:    n_state = (w_rem != '0) ? S_OUT : S_K;
            S_T:     n_state = S_TCHK;
            S_TCHK:  n_state = w_t_over ? S_OUT : S_FN;
            S_FN:    n_state = w_ctl.start ? S_DIVW : S_OUT;
            S_FN2:   n_state = S_OUT;
            S_DIVW:  n_state = w_done ? r_ret : S_DIVW;
            S_OUT:   n_state = w_out_load ? S_IDLE : S_OUT;
            S_EDIV, S_XG, S_MG, S_INV, S_R1, S_R2, S_R1Y, S_DG, S_K:
                     n_state = S_DIVW;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_out_load) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_prod <= w_ma * w_mb;
        if (w_ctl.start) begin
            r_ret <= w_ret;
        end
        if (w_out_load) begin
            r_out.res_begin <= RES_W'(r_rb);
            r_out.res_step  <= RES_W'(r_rs);
            r_out.res_end   <= RES_W'(r_re);
            r_out.res_empty <= r_rempty;
            r_out.res_valid <= r_rvalid;
        end
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    r_func <= i_in.func;
                    r_ab   <= i_in.a_begin;
                    r_ae   <= i_in.a_end;
                    r_as   <= (i_in.a_step == '0) ? SW'(1) : i_in.a_step;
                    r_bb   <= i_in.b_begin;
                    r_be   <= i_in.b_end;
                    r_bs   <= (i_in.b_step == '0) ? SW'(1) : i_in.b_step;
                end
            end
            S_NA: begin
                if (r_ae < r_ab) begin
                    r_ab <= VW'(1);
                    r_as <= SW'(1);
                    r_ae <= '0;
                end
            end
            S_NA2: begin
                r_ae <= w_ae_rnd;
                r_as <= (r_ab == w_ae_rnd) ? SW'(1) : r_as;
            end
            S_NB: begin
                if (r_be < r_bb) begin
                    r_bb <= VW'(1);
                    r_bs <= SW'(1);
                    r_be <= '0;
                end
            end
            S_NB2: begin
                r_be <= w_be_rnd;
                r_bs <= (r_bb == w_be_rnd) ? SW'(1) : r_bs;
            end
            S_DISP: begin
                // Compact: adjacency in either order; equal steps go on to an overlap test, unequal ones are rejected.
                if (r_func == FUNC_COMPACT) begin
                    if (w_c1) begin
                        r_fb <= r_ab;
                        r_fs <= LW'(r_as);
                        r_fe <= r_be;
                    end else if (w_c2) begin
                        r_fb <= r_bb;
                        r_fs <= LW'(r_as);
                        r_fe <= r_ae;
                    end else if (!w_eq_step) begin
                        r_rb     <= VW'(1);
                        r_rs     <= LW'(1);
                        r_re     <= '0;
                        r_rempty <= 1'b1;
                        r_rvalid <= 1'b0;
                    end
                end
            end
            S_ICHK: begin
                if (w_iempty) begin
                    r_rb     <= VW'(1);
                    r_rs     <= LW'(1);
                    r_re     <= '0;
                    r_rempty <= 1'b1;
                    r_rvalid <= r_func == FUNC_ISECT;
                end else begin
                    r_maxb <= (r_ab > r_bb) ? r_ab : r_bb;
                    r_mine <= (r_ae < r_be) ? r_ae : r_be;
                    r_eor  <= r_as;
                    r_er   <= r_bs;
                    r_eos  <= (LW+1)'(1);
                    r_es   <= '0;
                end
            end
            S_EUPD: begin
                r_eor <= r_er;
                r_er  <= w_rem[SW-1:0];
                r_eos <= r_es;
                r_es  <= w_enew;
            end
            S_MG:  r_xp  <= w_quo[SW-1:0];
            S_LCM: r_m2  <= w_quo[SW-1:0];
            S_INV: r_lcm <= r_prod;
            S_R1: begin
                // Bring the Euclid coefficient into [0, m2).
                r_inv <= (r_eos[LW] && (w_rem != '0)) ? (r_m2 - w_rem[SW-1:0])
                                                      : w_rem[SW-1:0];
            end
            S_R2:  r_r1 <= (w_rem == '0) ? '0 : (r_as - w_rem[SW-1:0]);
            S_R1Y: r_r2 <= (w_rem == '0) ? '0 : (r_bs - w_rem[SW-1:0]);
            S_QI: begin
                // Residues that disagree modulo the gcd leave no common member.
                if (w_rem != '0) begin
                    r_rb     <= VW'(1);
                    r_rs     <= LW'(1);
                    r_re     <= '0;
                    r_rempty <= 1'b1;
                    r_rvalid <= r_func == FUNC_ISECT;
                end
            end
            S_TCHK: begin
                if (w_t_over) begin
                    r_rb     <= VW'(1);
                    r_rs     <= LW'(1);
                    r_re     <= '0;
                    r_rempty <= 1'b1;
                    r_rvalid <= r_func == FUNC_ISECT;
                end else if (r_func == FUNC_COMPACT) begin
                    r_fb <= (r_ab < r_bb) ? r_ab : r_bb;
                    r_fs <= LW'(r_as);
                    r_fe <= (r_ae > r_be) ? r_ae : r_be;
                end else begin
                    r_fb <= r_maxb + VW'(w_t);
                    r_fs <= r_lcm;
                    r_fe <= r_mine;
                end
            end
            S_FN: begin
                if (r_fe < r_fb) begin
                    r_rb     <= VW'(1);
                    r_rs     <= LW'(1);
                    r_re     <= '0;
                    r_rempty <= 1'b1;
                    r_rvalid <= 1'b1;
                end
            end
            S_FN2: begin
                r_rb     <= r_fb;
                r_re     <= w_fe_rnd;
                r_rs     <= (r_fb == w_fe_rnd) ? LW'(1) : r_fs;
                r_rempty <= 1'b0;
                r_rvalid <= 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign o_stall = r_state != S_IDLE;
    assign o_valid = r_ovalid;
    assign o_out   = r_out;

    assign w_empty_out  = o_valid && o_out.res_empty;
    assign w_code_ok    = (o_out.res_begin == RES_W'(1)) && (o_out.res_end == '0)
                          && (o_out.res_step == RES_W'(1));
    assign w_reject_out = o_valid && !o_out.res_valid;

    // An accepted transaction closes the input side in the following cycle.
    `SIIM_ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n, w_accept, o_stall, "accept not held")
    // An empty result always carries the empty code.
    `SIIM_ASSERT_IMP(a_empty_code, i_clk, i_rst_n, w_empty_out, w_code_ok, "empty not coded")
    // A failed merge reports the empty interval.
    `SIIM_ASSERT_IMP(a_reject_empty, i_clk, i_rst_n, w_reject_out, o_out.res_empty, "reject not empty")

endmodule
`default_nettype wire

// ===== tb/tb_checker.sv =====
module tb_checker import siim_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  t_in  i_in,
    input  logic o_stall,
    input  logic o_valid,
    input  t_out o_out,
    input  logic i_stall,
    output int   o_err_cnt,
    output int   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        longint b;
        longint unsigned s;
        longint e;
    } t_ivl;

    t_out result_q[$];
    int   err_cnt = 0;

    assign o_err_cnt = err_cnt;
    assign o_pending = result_q.size();

    function automatic t_ivl empty_code();
        t_ivl r;
        r.b = 1;
        r.s = 1;
        r.e = 0;
        return r;
    endfunction

    function automatic t_ivl normalize(longint b, longint unsigned s, longint e);
        t_ivl r;
        longint unsigned span;
        if (e < b) return empty_code();
        if (s == 0) s = 1;
        span = e - b;
        r.b = b;
        r.e = e - longint'(span % s);
        r.s = (r.b == r.e) ? 1 : s;
        return r;
    endfunction

    function automatic longint unsigned gcd64(longint unsigned x, longint unsigned y);
        longint unsigned t;
        while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
        end
        return x;
    endfunction

    // Brute force CRT is too slow for 16-bit moduli, so use the extended Euclid.
    function automatic longint unsigned inv_mod(longint unsigned a, longint unsigned m);
        longint r0, r1, s0, s1, q, t;
        if (m <= 1) return 0;
        r0 = a % m;
        r1 = m;
        s0 = 1;
        s1 = 0;
        while (r1 != 0) begin
            q = r0 / r1;
            t = r0 - q * r1; r0 = r1; r1 = t;
            t = s0 - q * s1; s0 = s1; s1 = t;
        end
        s0 = s0 % longint'(m);
        if (s0 < 0) s0 += m;
        return s0;
    endfunction

    function automatic t_ivl intersect_ivl(t_ivl x, t_ivl y);
        longint maxb, mine;
        longint unsigned g, lcm, r1, r2, m2, q, k, t;
        if (x.e < x.b || y.e < y.b) return empty_code();
        if (x.e < y.b || y.e < x.b) return empty_code();
        maxb = (x.b > y.b) ? x.b : y.b;
        mine = (x.e < y.e) ? x.e : y.e;
        g = gcd64(x.s, y.s);
        lcm = (x.s / g) * y.s;
        r1 = (x.s - longint'(maxb - x.b) % x.s) % x.s;
        r2 = (y.s - longint'(maxb - y.b) % y.s) % y.s;
        if (r1 % g != r2 % g) return empty_code();
        m2 = y.s / g;
        q = ((r2 + y.s - r1 % y.s) % y.s) / g;
        k = ((q % m2) * inv_mod((x.s / g) % m2, m2)) % m2;
        t = r1 + x.s * k;
        if (t > longint'(mine - maxb)) return empty_code();
        return normalize(maxb + longint'(t), lcm, mine);
    endfunction

    function automatic t_out predict_result(t_in it);
        t_ivl a, b, r;
        t_out o;
        logic ok;
        ok = 1'b1;
        a = normalize(longint'(it.a_begin), it.a_step, longint'(it.a_end));
        b = normalize(longint'(it.b_begin), it.b_step, longint'(it.b_end));
        if (it.func == FUNC_ISECT) begin
            r = intersect_ivl(a, b);
        end else if (a.s == b.s && b.b > a.e && b.b - a.e == a.s) begin
            r = normalize(a.b, a.s, b.e);
        end else if (a.s == b.s && a.b > b.e && a.b - b.e == a.s) begin
            r = normalize(b.b, a.s, a.e);
        end else if (a.s == b.s && !(intersect_ivl(a, b).e < intersect_ivl(a, b).b)) begin
            r = normalize(a.b < b.b ? a.b : b.b, a.s, a.e > b.e ? a.e : b.e);
        end else begin
            r = empty_code();
            ok = 1'b0;
        end
        o.res_begin = r.b[31:0];
        o.res_step  = r.s[31:0];
        o.res_end   = r.e[31:0];
        o.res_empty = r.e < r.b;
        o.res_valid = ok;
        return o;
    endfunction

    always @(posedge i_clk) begin
        t_out exp_res;
        if (i_rst_n) begin
            if (i_valid && !o_stall) result_q.push_back(predict_result(i_in));
            if (o_valid && !i_stall) begin
                if (result_q.size() == 0) begin
                    err_cnt++;
                    if (err_cnt <= 10) $display("Unexpected result transaction %p", o_out);
                end else begin
                    exp_res = result_q.pop_front();
                    if (o_out !== exp_res) begin
                        err_cnt++;
                        if (err_cnt <= 10)
                            $display("Mismatch: expected %p, got %p", exp_res, o_out);
                    end
                end
            end
        end
    end
endmodule

// ===== tb/tb_top.sv =====
// Top of the testbench: makes stimulus and idles both channels at random. The checker
// beside the block predicts every result and counts failures.
module tb_top;
    import siim_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 8_000_000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    t_in  i_in = '0;
    logic o_stall;
    logic o_valid;
    t_out o_out;
    logic i_stall = 1'b0;
    int   err_cnt;
    int   pending;
    int   cycle_cnt = 0;
    int   stall_left = 0;

    always #1 i_clk = ~i_clk;

    strided_interval_intersect_merge_core i_dut (.*);

    tb_checker i_chk (
        .i_clk, .i_rst_n, .i_valid, .i_in, .o_stall, .o_valid, .o_out, .i_stall,
        .o_err_cnt(err_cnt), .o_pending(pending)
    );

    // Mostly short gaps, sometimes a long one.
    function automatic int gap_len();
        int p;
        p = $urandom_range(99);
        if (p < 50) return 0;
        if (p < 92) return $urandom_range(1, 4);
        return $urandom_range(20, 400);
    endfunction

    // The receiver stalls in runs of random length; it never depends on the sender.
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            i_stall    <= 1'b1;
            stall_left <= stall_left - 1;
        end else if ($urandom_range(99) < 20) begin
            i_stall    <= 1'b1;
            stall_left <= gap_len();
        end else begin
            i_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // One transaction: hold valid until accepted, then idle for a random gap, which may be zero.
    task automatic send_item(t_in it);
        int g;
        i_in <= it;
        i_valid <= 1'b1;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        g = gap_len();
        if (g > 0) begin
            i_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    function automatic logic [31:0] rand_value();
        case ($urandom_range(3))
            0: return $urandom();
            1: return $urandom_range(200) - 100;
            2: return {1'b0, {31{1'b1}}} - $urandom_range(50);
            default: return {1'b1, 31'd0} + $urandom_range(50);
        endcase
    endfunction

    function automatic logic [15:0] rand_step();
        case ($urandom_range(3))
            0: return 16'($urandom());
            1: return 16'($urandom_range(12));
            2: return 16'hffff - 16'($urandom_range(3));
            default: return 16'($urandom_range(200));
        endcase
    endfunction

    // Related pairs: overlapping, adjacent or nearby progressions, often with equal steps,
    // so that many intersections are non-empty and compact often finds something to merge.
    function automatic t_in related_item();
        t_in it;
        int unsigned n;
        it.func    = 1'($urandom_range(1));
        it.a_begin = rand_value();
        it.a_step  = rand_step();
        n = $urandom_range(3) == 0 ? 0 : $urandom_range(40);
        it.a_end   = it.a_begin + n * it.a_step + $urandom_range(2);
        it.b_step  = ($urandom_range(1) == 1) ? it.a_step : rand_step();
        case ($urandom_range(2))
            0: it.b_begin = it.a_end + it.a_step;
            1: it.b_begin = it.a_begin + $urandom_range(20) * it.a_step;
            default: it.b_begin = it.a_begin + $urandom_range(300) - 150;
        endcase
        it.b_end   = it.b_begin + $urandom_range(40) * it.b_step + $urandom_range(2);
        if ($urandom_range(1) == 1) begin
            {it.a_begin, it.a_step, it.a_end, it.b_begin, it.b_step, it.b_end} =
                {it.b_begin, it.b_step, it.b_end, it.a_begin, it.a_step, it.a_end};
        end
        // Where a sum wrapped past the signed range, mostly clamp the end to the begin.
        if (it.a_end < it.a_begin && $urandom_range(3) != 0) it.a_end = it.a_begin;
        if (it.b_end < it.b_begin && $urandom_range(3) != 0) it.b_end = it.b_begin;
        return it;
    endfunction

    function automatic t_in mk(logic f, int ab, int as_, int ae, int bb, int bs, int be);
        t_in it;
        it.func = f;
        it.a_begin = ab; it.a_step = 16'(as_); it.a_end = ae;
        it.b_begin = bb; it.b_step = 16'(bs); it.b_end = be;
        return it;
    endfunction

    initial begin
        t_in it;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed cases: both operations, empties, zero step, unnormalized ends,
        // single members, merges of adjacent and overlapping intervals, extremes.
        send_item(mk(FUNC_ISECT, 0, 2, 20, 1, 3, 30));
        send_item(mk(FUNC_ISECT, 0, 4, 20, 1, 2, 30));
        send_item(mk(FUNC_ISECT, 5, 1, 4, 0, 1, 9));
        send_item(mk(FUNC_ISECT, 0, 0, 10, 3, 0, 7));
        send_item(mk(FUNC_ISECT, 0, 3, 11, 0, 5, 31));
        send_item(mk(FUNC_ISECT, 7, 9, 7, 0, 1, 10));
        send_item(mk(FUNC_ISECT, 0, 1, 5, 10, 1, 20));
        send_item(mk(FUNC_ISECT, 32'h8000_0000, 16'hffff, 32'h7fff_ffff,
                     32'h8000_0001, 16'hfffe, 32'h7fff_ffff));
        send_item(mk(FUNC_ISECT, 32'h8000_0000, 16'hfff1, 32'h7fff_ffff,
                     32'h8000_0000, 16'hffff, 32'h7fff_ffff));
        send_item(mk(FUNC_COMPACT, 0, 3, 9, 12, 3, 21));
        send_item(mk(FUNC_COMPACT, 12, 3, 21, 0, 3, 9));
        send_item(mk(FUNC_COMPACT, 0, 3, 15, 6, 3, 30));
        send_item(mk(FUNC_COMPACT, 0, 3, 9, 13, 3, 21));
        send_item(mk(FUNC_COMPACT, 0, 2, 9, 0, 3, 9));
        send_item(mk(FUNC_COMPACT, 5, 1, 4, 1, 1, 8));
        send_item(mk(FUNC_COMPACT, 5, 1, 4, 9, 1, 2));
        send_item(mk(FUNC_COMPACT, 0, 0, 4, 5, 0, 9));
        send_item(mk(FUNC_COMPACT, 32'h8000_0000, 16'hffff, 32'h7fff_ffff,
                     32'h8000_0000, 16'hffff, 32'h7fff_ffff));
        send_item(mk(FUNC_COMPACT, 32'hffff_ffff, 16'hffff, 32'hffff_ffff,
                     32'h0000_fffe, 16'hffff, 32'h0000_fffe));
        send_item(mk(FUNC_ISECT, 32'h7fff_ffff, 1, 32'h7fff_ffff,
                     32'h7fff_ffff, 1, 32'h7fff_ffff));

        for (int n = 0; n < 850; n++) begin
            if ($urandom_range(9) < 8) begin
                it = related_item();
            end else begin
                it = mk(1'($urandom_range(1)), $urandom(), $urandom(), $urandom(),
                        $urandom(), $urandom(), $urandom());
            end
            send_item(it);
        end
        i_valid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (1000) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
+incdir+src
src/siim_pkg.sv
src/siim_div.sv
src/strided_interval_intersect_merge_core.sv
tb/tb_checker.sv
tb/tb_top.sv
